[hdl/ebe_pkg.sv]
// ----------------------------------------------------------------------------
// ebe_pkg: shared types and constants
// Item layouts, request codes, control bundles and helpers for the
// element-by-element triangle matrix-vector block.
// ----------------------------------------------------------------------------
package ebe_pkg;

  localparam int unsigned MAX_EQ  = 4096;
  localparam int unsigned ADDR_W  = $clog2(MAX_EQ);
  localparam int unsigned IDX_W   = 13;
  localparam int unsigned VEC_W   = 32;
  localparam int unsigned PROD_W  = 2 * VEC_W;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned SUM_W   = PROD_W + 2;
  localparam int unsigned ROW_W   = SUM_W - FRAC_W;
  localparam int unsigned NUM_LANES = 3;

  localparam logic [IDX_W-1:0] EQ_COUNT_RESET = IDX_W'(MAX_EQ);
  localparam logic [IDX_W-1:0] MAX_EQ_IDX     = IDX_W'(MAX_EQ);

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_ROW  = 2'd1,
    REQ_READ = 2'd2
  } req_type_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [11:0]             entry_index;
    logic signed [31:0]      vec_value;
    logic [1:0]              row_sel;
    logic [IDX_W-1:0]        node_a;
    logic [IDX_W-1:0]        node_b;
    logic [IDX_W-1:0]        node_c;
    logic signed [31:0]      coef_0;
    logic signed [31:0]      coef_1;
    logic signed [31:0]      coef_2;
  } in_item_t;

  typedef struct packed {
    logic [11:0]             result_index;
    logic signed [47:0]      result_value;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic              mul_en;
  } lane_ctrl_t;

  typedef struct packed {
    logic              clr_en;
    logic [ADDR_W-1:0] clr_addr;
    logic              q_rd_en;
    logic [ADDR_W-1:0] q_rd_addr;
    logic              sum_en;
    logic              row_en;
    logic              acc_en;
    logic [ADDR_W-1:0] acc_addr;
  } merge_ctrl_t;

  function automatic logic is_live(logic [IDX_W-1:0] idx, logic [IDX_W-1:0] eq_count);
    return (idx < eq_count) && (idx < MAX_EQ_IDX);
  endfunction

endpackage

[hdl/ebe_lane.sv]
// ----------------------------------------------------------------------------
// ebe_lane: one node lane
// Holds a private copy of the vector store, reads the entry of its node
// and multiplies it by the lane coefficient into an exact Q32.32 product.
// ----------------------------------------------------------------------------
module ebe_lane
  import ebe_pkg::*;
(
  input  logic                     clk_i,
  input  lane_ctrl_t               ctrl_i,
  input  logic signed [VEC_W-1:0]  wr_data_i,
  input  logic [ADDR_W-1:0]        rd_addr_i,
  input  logic                     rd_live_i,
  input  logic signed [VEC_W-1:0]  coef_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [VEC_W-1:0]  vec_mem [MAX_EQ];
  logic signed [VEC_W-1:0]  rd_data_q;
  logic                     rd_live_q;
  logic signed [VEC_W-1:0]  operand;
  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      vec_mem[ctrl_i.wr_addr] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= vec_mem[rd_addr_i];
      rd_live_q <= rd_live_i;
    end
  end

  // dummy or out-of-range nodes read as zero
  assign operand = rd_live_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= operand * coef_i;
    end
  end

  assign prod_o = prod_q;

endmodule

[hdl/ebe_merge.sv]
// ----------------------------------------------------------------------------
// ebe_merge: lane merge and accumulate
// Sums the three lane products, floors the sum to Q34.16 and adds it into
// the result store with saturation to the signed 48-bit range.
// ----------------------------------------------------------------------------
module ebe_merge
  import ebe_pkg::*;
(
  input  logic                     clk_i,
  input  merge_ctrl_t              ctrl_i,
  input  logic signed [PROD_W-1:0] prod_a_i,
  input  logic signed [PROD_W-1:0] prod_b_i,
  input  logic signed [PROD_W-1:0] prod_c_i,
  output logic signed [ACC_W-1:0]  q_data_o
);

  localparam logic signed [ACC_W:0] AccMax = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] AccMin = {2'b11, {(ACC_W-1){1'b0}}};

  logic signed [ACC_W-1:0]  acc_mem [MAX_EQ];
  logic signed [ACC_W-1:0]  q_data_q;
  logic signed [SUM_W-1:0]  sum_ab_q;
  logic signed [PROD_W-1:0] prod_c_q;
  logic signed [SUM_W-1:0]  sum_all;
  logic signed [ROW_W-1:0]  row_q;
  logic signed [ROW_W:0]    acc_sum;
  logic signed [ACC_W-1:0]  acc_sat;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [ACC_W-1:0]  wr_data;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      sum_ab_q <= SUM_W'(prod_a_i) + SUM_W'(prod_b_i);
      prod_c_q <= prod_c_i;
    end
  end

  assign sum_all = sum_ab_q + SUM_W'(prod_c_q);

  // arithmetic shift gives the floor of the scaled sum
  always_ff @(posedge clk_i) begin
    if (ctrl_i.row_en) begin
      row_q <= sum_all[SUM_W-1:FRAC_W];
    end
  end

  assign acc_sum = (ROW_W+1)'(q_data_q) + (ROW_W+1)'(row_q);

  always_comb begin
    if (acc_sum > (ROW_W+1)'(AccMax)) begin
      acc_sat = AccMax[ACC_W-1:0];
    end else if (acc_sum < (ROW_W+1)'(AccMin)) begin
      acc_sat = AccMin[ACC_W-1:0];
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  assign wr_en   = ctrl_i.clr_en | ctrl_i.acc_en;
  assign wr_addr = ctrl_i.acc_en ? ctrl_i.acc_addr : ctrl_i.clr_addr;
  assign wr_data = ctrl_i.acc_en ? acc_sat : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      acc_mem[wr_addr] <= wr_data;
    end
    if (ctrl_i.q_rd_en) begin
      q_data_q <= acc_mem[ctrl_i.q_rd_addr];
    end
  end

  assign q_data_o = q_data_q;

endmodule

[hdl/ebe_triangle_matvec.sv]
// ----------------------------------------------------------------------------
// ebe_triangle_matvec: element-by-element triangle matrix-vector product
// Accumulates Q = sum of element rows times P over three parallel lanes.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_stall_o / in_item_i, one request per item
//   out channel : out_valid_o / out_stall_i / out_item_o, one item per read
//   cfg port    : cfg_we_i writes eq_count from cfg_data_i; user must do so only while idle (unenforced)
// Steps, one item at a time:
//   load item   : writes P and clears Q at the accept edge
//   row item    : lane read, multiply, two merge adds, Q update
//   read item   : store read, then the output register loads once it is free
// The three lane memories give one P read per node each, and the single
// result store port sets the row sequence. The next item is taken while an
// output item still waits; a read finishing into a stalled output holds
// until the output register frees.
// Reset clears the sequencer, the output valid and sets eq_count to 4096.
// The stores are not cleared: each live entry must be loaded before use.
// ----------------------------------------------------------------------------
module ebe_triangle_matvec
  import ebe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_data_i
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SUM1 = 6'b000100,
    ST_SUM2 = 6'b001000,
    ST_ACC  = 6'b010000,
    ST_RD   = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic [IDX_W-1:0]         eq_count_q;
  in_item_t                 item_q;
  logic                     sel_live_q;
  logic [ADDR_W-1:0]        sel_addr_q;
  logic                     rd_live_q;
  logic                     out_valid_q;
  out_item_t                out_item_q;
  logic                     accept;
  logic                     out_free;
  logic                     load_live;
  logic                     sel_live;
  logic [IDX_W-1:0]         sel_node;
  lane_ctrl_t               lane_ctrl;
  merge_ctrl_t              merge_ctrl;
  logic signed [PROD_W-1:0] prod_a, prod_b, prod_c;
  logic signed [ACC_W-1:0]  q_data;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_live  = is_live({1'b0, in_item_i.entry_index}, eq_count_q);

  always_comb begin
    case (in_item_i.row_sel)
      2'd0:    sel_node = in_item_i.node_a;
      2'd1:    sel_node = in_item_i.node_b;
      default: sel_node = in_item_i.node_c;
    endcase
  end

  // selector three computes the row but writes nowhere
  assign sel_live = (in_item_i.row_sel != 2'd3) && is_live(sel_node, eq_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eq_count_q <= EQ_COUNT_RESET;
    end else if (cfg_we_i) begin
      eq_count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= in_item_i;
      sel_live_q <= sel_live;
      sel_addr_q <= sel_node[ADDR_W-1:0];
      rd_live_q  <= load_live;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.req_type)
            REQ_ROW:  state_d = ST_MUL;
            REQ_READ: state_d = ST_RD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL:  state_d = ST_SUM1;
      ST_SUM1: state_d = ST_SUM2;
      ST_SUM2: state_d = ST_ACC;
      ST_ACC:  state_d = ST_IDLE;
      ST_RD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    lane_ctrl.wr_en   = accept && (in_item_i.req_type == REQ_LOAD) && load_live;
    lane_ctrl.wr_addr = in_item_i.entry_index[ADDR_W-1:0];
    lane_ctrl.rd_en   = accept && (in_item_i.req_type == REQ_ROW);
    lane_ctrl.mul_en  = (state_q == ST_MUL);
  end

  always_comb begin
    merge_ctrl.clr_en    = lane_ctrl.wr_en;
    merge_ctrl.clr_addr  = in_item_i.entry_index[ADDR_W-1:0];
    merge_ctrl.q_rd_en   = (accept && (in_item_i.req_type == REQ_READ))
                           || (state_q == ST_SUM1);
    merge_ctrl.q_rd_addr = (state_q == ST_SUM1) ? sel_addr_q
                                                : in_item_i.entry_index[ADDR_W-1:0];
    merge_ctrl.sum_en    = (state_q == ST_SUM1);
    merge_ctrl.row_en    = (state_q == ST_SUM2);
    merge_ctrl.acc_en    = (state_q == ST_ACC) && sel_live_q;
    merge_ctrl.acc_addr  = sel_addr_q;
  end

  ebe_lane u_lane_a (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .wr_data_i (in_item_i.vec_value),
    .rd_addr_i (in_item_i.node_a[ADDR_W-1:0]),
    .rd_live_i (is_live(in_item_i.node_a, eq_count_q)),
    .coef_i    (item_q.coef_0),
    .prod_o    (prod_a)
  );

  ebe_lane u_lane_b (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .wr_data_i (in_item_i.vec_value),
    .rd_addr_i (in_item_i.node_b[ADDR_W-1:0]),
    .rd_live_i (is_live(in_item_i.node_b, eq_count_q)),
    .coef_i    (item_q.coef_1),
    .prod_o    (prod_b)
  );

  ebe_lane u_lane_c (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .wr_data_i (in_item_i.vec_value),
    .rd_addr_i (in_item_i.node_c[ADDR_W-1:0]),
    .rd_live_i (is_live(in_item_i.node_c, eq_count_q)),
    .coef_i    (item_q.coef_2),
    .prod_o    (prod_c)
  );

  ebe_merge u_merge (
    .clk_i    (clk_i),
    .ctrl_i   (merge_ctrl),
    .prod_a_i (prod_a),
    .prod_b_i (prod_b),
    .prod_c_i (prod_c),
    .q_data_o (q_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_RD) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RD) && out_free) begin
      out_item_q.result_index <= item_q.entry_index;
      out_item_q.result_value <= rd_live_q ? q_data : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for ebe_triangle_matvec
// Drives load, row, read and ignored requests through the valid/stall input
// channel with random gaps, stalls the result channel at random, and checks
// every returned entry against a bit-accurate product model in the bench or
// a value typed into the short directed table, which covers saturation,
// dummy-equation and out-of-range cases, then random phases under several eq_count values.
// ----------------------------------------------------------------------------
module tb;
  import ebe_pkg::*;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned TIMEOUT      = 2_000_000;
  localparam int unsigned NODE_TOP     = 8191;

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;

  localparam logic [1:0] REQ_IGNORED  = 2'd3;
  localparam logic [1:0] ROW_SEL_A    = 2'd0;
  localparam logic [1:0] ROW_SEL_B    = 2'd1;
  localparam logic [1:0] ROW_SEL_C    = 2'd2;
  localparam logic [1:0] ROW_SEL_NONE = 2'd3;

  typedef struct {
    in_item_t    item;
    bit          typed;
    logic [47:0] value;
  } stim_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_item_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_item_o;
  logic             cfg_we_i    = 1'b0;
  logic [IDX_W-1:0] cfg_data_i  = '0;

  // expected value typed into the directed table, travels with the item
  bit               typed_tag   = 1'b0;
  logic [47:0]      typed_value = '0;

  logic signed [31:0] p_entries [MAX_EQ];
  longint             q_entries [MAX_EQ];
  logic [IDX_W-1:0]   eq_count_model;
  out_item_t          expected_reads [$];
  out_item_t          got_read;
  out_item_t          next_read;
  int unsigned        work_set [$];
  bit                 in_burst  = 1'b0;
  bit                 out_burst = 1'b0;
  bit                 failed    = 1'b0;

  ebe_triangle_matvec dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic bit entry_active(logic [IDX_W-1:0] idx);
    return (idx < eq_count_model) && (idx < MAX_EQ);
  endfunction

  // advances the P/Q model by one request, returns 1 when a read answers
  function automatic bit apply_request(input in_item_t it, output out_item_t res);
    logic [IDX_W-1:0]   node [3];
    logic signed [31:0] coef [3];
    logic signed [65:0] dot;
    logic [IDX_W-1:0]   dst;
    longint             acc;
    int                 k;
    res  = '0;
    node = '{it.node_a, it.node_b, it.node_c};
    coef = '{it.coef_0, it.coef_1, it.coef_2};
    dot  = '0;
    case (it.req_type)
      REQ_LOAD: begin
        if (entry_active({1'b0, it.entry_index})) begin
          p_entries[it.entry_index] = it.vec_value;
          q_entries[it.entry_index] = 0;
        end
        return 1'b0;
      end
      REQ_ROW: begin
        for (k = 0; k < 3; k++) begin
          if (entry_active(node[k])) begin
            dot += longint'(coef[k]) * longint'(p_entries[node[k][ADDR_W-1:0]]);
          end
        end
        if (it.row_sel != ROW_SEL_NONE) begin
          dst = node[it.row_sel];
          if (entry_active(dst)) begin
            // floor to Q34.16, then saturate to 48 bits
            acc = q_entries[dst[ADDR_W-1:0]] + longint'(dot >>> FRAC_W);
            if (acc > ACC_HI) begin
              acc = ACC_HI;
            end else if (acc < ACC_LO) begin
              acc = ACC_LO;
            end
            q_entries[dst[ADDR_W-1:0]] = acc;
          end
        end
        return 1'b0;
      end
      REQ_READ: begin
        res.result_index = it.entry_index;
        if (entry_active({1'b0, it.entry_index})) begin
          res.result_value = q_entries[it.entry_index][47:0];
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      eq_count_model = EQ_COUNT_RESET;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_reads.size() == 0) begin
          $error("result_index %0d arrived with no read pending", out_item_o.result_index);
          failed = 1'b1;
        end else begin
          got_read = expected_reads.pop_front();
          if (out_item_o.result_index !== got_read.result_index) begin
            $error("result_index: expected %0d, got %0d",
                   got_read.result_index, out_item_o.result_index);
            failed = 1'b1;
          end
          if (out_item_o.result_value !== got_read.result_value) begin
            $error("result_value: expected %0d, got %0d",
                   got_read.result_value, out_item_o.result_value);
            failed = 1'b1;
          end
        end
      end
      if (cfg_we_i) begin
        eq_count_model = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o && apply_request(in_item_i, next_read)) begin
        if (typed_tag) begin
          next_read.result_value = typed_value;
        end
        expected_reads.push_back(next_read);
      end
    end
  end

  initial begin : result_stall
    int unsigned hold;
    wait (rst_ni);
    forever begin
      hold = out_burst ? 0 : $urandom_range(9, 0);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic in_item_t load_req(int unsigned idx, logic [31:0] v);
    in_item_t it;
    it             = '0;
    it.req_type    = REQ_LOAD;
    it.entry_index = 12'(idx);
    it.vec_value   = v;
    return it;
  endfunction

  function automatic in_item_t read_req(int unsigned idx);
    in_item_t it;
    it             = '0;
    it.req_type    = REQ_READ;
    it.entry_index = 12'(idx);
    return it;
  endfunction

  function automatic in_item_t row_req(logic [1:0] sel, int unsigned a, int unsigned b,
                                       int unsigned c, logic [31:0] k0, logic [31:0] k1,
                                       logic [31:0] k2);
    in_item_t it;
    it          = '0;
    it.req_type = REQ_ROW;
    it.row_sel  = sel;
    it.node_a   = IDX_W'(a);
    it.node_b   = IDX_W'(b);
    it.node_c   = IDX_W'(c);
    it.coef_0   = k0;
    it.coef_1   = k1;
    it.coef_2   = k2;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    logic [191:0] noise;
    noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return noise[$bits(in_item_t)-1:0];
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(9, 0))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom();
      default: return 32'($urandom_range(32'h3_FFFF, 0)) - 32'h2_0000;
    endcase
  endfunction

  function automatic logic [11:0] pick_entry(int unsigned eq);
    if (work_set.size() == 0 || (eq < MAX_EQ && $urandom_range(6, 0) == 0)) begin
      return 12'($urandom_range(MAX_EQ - 1, eq));
    end
    return 12'(work_set[$urandom_range(work_set.size() - 1, 0)]);
  endfunction

  function automatic logic [IDX_W-1:0] pick_node(int unsigned live_top);
    if (work_set.size() == 0 || $urandom_range(6, 0) == 0) begin
      return IDX_W'($urandom_range(NODE_TOP, live_top));
    end
    return IDX_W'(work_set[$urandom_range(work_set.size() - 1, 0)]);
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input logic [47:0] value);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(9, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_item_i   <= it;
    typed_tag   <= typed;
    typed_value <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_eq_count(input int unsigned value);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= IDX_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned eq, input int unsigned n_items);
    int unsigned live_top;
    int unsigned counted;
    int unsigned pick;
    in_item_t    it;
    set_eq_count(eq);
    live_top = (eq < MAX_EQ) ? eq : MAX_EQ;
    work_set.delete();
    if (live_top <= 24) begin
      for (int unsigned i = 0; i < live_top; i++) work_set.push_back(i);
    end else begin
      work_set.push_back(0);
      work_set.push_back(live_top - 1);
      repeat (12) work_set.push_back($urandom_range(live_top - 1, 1));
    end
    // every live entry in use gets loaded first
    foreach (work_set[i]) begin
      it             = rand_item();
      it.req_type    = REQ_LOAD;
      it.entry_index = 12'(work_set[i]);
      it.vec_value   = rand_q16();
      send_item(it, 1'b0, '0);
    end
    counted = 0;
    while (counted < n_items) begin
      if (counted % 40 == 0) begin
        in_burst  = ($urandom_range(3, 0) == 0);
        out_burst = ($urandom_range(3, 0) == 0);
      end
      it   = rand_item();
      pick = $urandom_range(99, 0);
      if (pick < 45) begin
        it.req_type = REQ_ROW;
        it.row_sel  = ($urandom_range(19, 0) == 0) ? ROW_SEL_NONE : 2'($urandom_range(2, 0));
        it.node_a   = pick_node(live_top);
        it.node_b   = pick_node(live_top);
        it.node_c   = pick_node(live_top);
        it.coef_0   = rand_q16();
        it.coef_1   = rand_q16();
        it.coef_2   = rand_q16();
        counted++;
      end else if (pick < 60) begin
        it.req_type    = REQ_LOAD;
        it.entry_index = pick_entry(eq);
        it.vec_value   = rand_q16();
        counted++;
      end else if (pick < 92) begin
        it.req_type    = REQ_READ;
        it.entry_index = pick_entry(eq);
        counted++;
      end else begin
        it.req_type = REQ_IGNORED;
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    stim_row_t   directed_rows [$];
    int unsigned eq_plan [$];
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_eq_count(8);
    directed_rows = '{
      '{load_req(0, 32'h0001_0000), 1'b0, '0},
      '{load_req(1, 32'h7FFF_FFFF), 1'b0, '0},
      '{load_req(2, 32'h8000_0000), 1'b0, '0},
      '{load_req(3, 32'hFFFF_FFFF), 1'b0, '0},
      '{load_req(7, 32'h0002_0000), 1'b0, '0},
      '{read_req(0), 1'b1, 48'h0},
      '{read_req(7), 1'b1, 48'h0},
      '{read_req(8), 1'b1, 48'h0},
      '{read_req(4095), 1'b1, 48'h0},
      '{load_req(9, 32'h1234_5678), 1'b0, '0},
      '{row_req(ROW_SEL_A, 0, 8, 8191, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000),
        1'b0, '0},
      '{read_req(0), 1'b1, 48'h0000_0002_0000},
      '{row_req(ROW_SEL_B, 1, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
        1'b0, '0},
      '{read_req(1), 1'b1, 48'h7FFF_FFFF_FFFF},
      '{row_req(ROW_SEL_C, 2, 2, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
        1'b0, '0},
      '{read_req(2), 1'b1, 48'h8000_0000_0000},
      '{row_req(ROW_SEL_A, 3, 0, 7, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000),
        1'b0, '0},
      '{row_req(ROW_SEL_NONE, 0, 1, 2, 32'h1357_9BDF, 32'hECA8_6420, 32'h7FFF_FFFF),
        1'b0, '0},
      '{read_req(0), 1'b1, 48'h0000_0002_0000},
      '{in_item_t'({REQ_IGNORED, {($bits(in_item_t) - 2){1'b0}}}), 1'b0, '0},
      '{row_req(ROW_SEL_A, 8, 0, 4096, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000),
        1'b0, '0},
      '{read_req(3), 1'b0, '0},
      '{row_req(ROW_SEL_B, 7, 1, 5000, 32'h8000_0000, 32'hFFFF_0000, 32'h7FFF_FFFF),
        1'b0, '0},
      '{read_req(1), 1'b0, '0}
    };
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].value);
    end
    eq_plan    = '{4096, 1, 8191, 0, 4095, 16, 2, 4096};
    eq_plan[6] = $urandom_range(64, 2);
    foreach (eq_plan[i]) run_phase(eq_plan[i], PHASE_ITEMS);
    wait_drained();
    if (!failed) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
hdl/ebe_pkg.sv
hdl/ebe_lane.sv
hdl/ebe_merge.sv
hdl/ebe_triangle_matvec.sv
dv/tb.sv
